// ===== src/stkd_pkg.sv =====
`timescale 1ns / 1ps

package stkd_pkg;

  // Decoder states.
  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_ESC   = 3'd1,
    ST_SS3   = 3'd2,
    ST_CSI   = 3'd3,
    ST_CSI1  = 3'd4,
    ST_CSI2  = 3'd5
  } stkd_state_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 7;

  // Special byte values.
  localparam logic [ByteW-1:0] BYTE_ESC = 8'h1b;
  localparam logic [ByteW-1:0] BYTE_SS3 = 8'h4f;
  localparam logic [ByteW-1:0] BYTE_CSI = 8'h5b;
  localparam logic [ByteW-1:0] BYTE_ONE = 8'h31;
  localparam logic [ByteW-1:0] BYTE_TWO = 8'h32;

  // Key codes.
  localparam logic [KeyW-1:0] K_NONE     = 7'd0;
  localparam logic [KeyW-1:0] K_BACKTICK = 7'd1;
  localparam logic [KeyW-1:0] K_D1       = 7'd2;
  localparam logic [KeyW-1:0] K_D2       = 7'd3;
  localparam logic [KeyW-1:0] K_D3       = 7'd4;
  localparam logic [KeyW-1:0] K_D4       = 7'd5;
  localparam logic [KeyW-1:0] K_D5       = 7'd6;
  localparam logic [KeyW-1:0] K_D6       = 7'd7;
  localparam logic [KeyW-1:0] K_D7       = 7'd8;
  localparam logic [KeyW-1:0] K_D8       = 7'd9;
  localparam logic [KeyW-1:0] K_D9       = 7'd10;
  localparam logic [KeyW-1:0] K_D0       = 7'd11;
  localparam logic [KeyW-1:0] K_MINUS    = 7'd12;
  localparam logic [KeyW-1:0] K_EQUALS   = 7'd13;
  localparam logic [KeyW-1:0] K_BKSP     = 7'd14;
  localparam logic [KeyW-1:0] K_TAB      = 7'd15;
  localparam logic [KeyW-1:0] K_Q        = 7'd16;
  localparam logic [KeyW-1:0] K_W        = 7'd17;
  localparam logic [KeyW-1:0] K_E        = 7'd18;
  localparam logic [KeyW-1:0] K_R        = 7'd19;
  localparam logic [KeyW-1:0] K_T        = 7'd20;
  localparam logic [KeyW-1:0] K_Y        = 7'd21;
  localparam logic [KeyW-1:0] K_U        = 7'd22;
  localparam logic [KeyW-1:0] K_I        = 7'd23;
  localparam logic [KeyW-1:0] K_O        = 7'd24;
  localparam logic [KeyW-1:0] K_P        = 7'd25;
  localparam logic [KeyW-1:0] K_LBR      = 7'd26;
  localparam logic [KeyW-1:0] K_RBR      = 7'd27;
  localparam logic [KeyW-1:0] K_A        = 7'd28;
  localparam logic [KeyW-1:0] K_S        = 7'd29;
  localparam logic [KeyW-1:0] K_D        = 7'd30;
  localparam logic [KeyW-1:0] K_F        = 7'd31;
  localparam logic [KeyW-1:0] K_G        = 7'd32;
  localparam logic [KeyW-1:0] K_H        = 7'd33;
  localparam logic [KeyW-1:0] K_J        = 7'd34;
  localparam logic [KeyW-1:0] K_K        = 7'd35;
  localparam logic [KeyW-1:0] K_L        = 7'd36;
  localparam logic [KeyW-1:0] K_SEMI     = 7'd37;
  localparam logic [KeyW-1:0] K_QUOTE    = 7'd38;
  localparam logic [KeyW-1:0] K_BSLASH   = 7'd39;
  localparam logic [KeyW-1:0] K_Z        = 7'd40;
  localparam logic [KeyW-1:0] K_X        = 7'd41;
  localparam logic [KeyW-1:0] K_C        = 7'd42;
  localparam logic [KeyW-1:0] K_V        = 7'd43;
  localparam logic [KeyW-1:0] K_B        = 7'd44;
  localparam logic [KeyW-1:0] K_N        = 7'd45;
  localparam logic [KeyW-1:0] K_M        = 7'd46;
  localparam logic [KeyW-1:0] K_COMMA    = 7'd47;
  localparam logic [KeyW-1:0] K_PERIOD   = 7'd48;
  localparam logic [KeyW-1:0] K_SLASH    = 7'd49;
  localparam logic [KeyW-1:0] K_SPACE    = 7'd50;
  localparam logic [KeyW-1:0] K_ESCAPE   = 7'd51;
  localparam logic [KeyW-1:0] K_ENTER    = 7'd52;
  localparam logic [KeyW-1:0] K_LSHIFT   = 7'd53;
  localparam logic [KeyW-1:0] K_F1       = 7'd54;
  localparam logic [KeyW-1:0] K_F5       = 7'd58;
  localparam logic [KeyW-1:0] K_F6       = 7'd59;
  localparam logic [KeyW-1:0] K_F7       = 7'd60;
  localparam logic [KeyW-1:0] K_F8       = 7'd61;
  localparam logic [KeyW-1:0] K_F9       = 7'd62;
  localparam logic [KeyW-1:0] K_UP       = 7'd66;
  localparam logic [KeyW-1:0] K_DOWN     = 7'd67;
  localparam logic [KeyW-1:0] K_LEFT     = 7'd68;
  localparam logic [KeyW-1:0] K_RIGHT    = 7'd69;

  // Event sequence positions: shift press, key press, key release, shift release.
  localparam logic [1:0] STEP_SHIFT_DN = 2'd0;
  localparam logic [1:0] STEP_KEY_DN   = 2'd1;
  localparam logic [1:0] STEP_KEY_UP   = 2'd2;
  localparam logic [1:0] STEP_SHIFT_UP = 2'd3;

  // Decoded request handed from the lookup stage to the event sequencer.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            shift;
    logic            single;
  } stkd_desc_t;

  // Printable character table: bit 7 is the shift flag, low bits the key.
  function automatic logic [7:0] ascii_lookup(input logic [6:0] ch);
    logic [7:0] r;
    r = {1'b0, K_NONE};
    case (ch)
      7'h60: r = {1'b0, K_BACKTICK};
      7'h31: r = {1'b0, K_D1};
      7'h32: r = {1'b0, K_D2};
      7'h33: r = {1'b0, K_D3};
      7'h34: r = {1'b0, K_D4};
      7'h35: r = {1'b0, K_D5};
      7'h36: r = {1'b0, K_D6};
      7'h37: r = {1'b0, K_D7};
      7'h38: r = {1'b0, K_D8};
      7'h39: r = {1'b0, K_D9};
      7'h30: r = {1'b0, K_D0};
      7'h2d: r = {1'b0, K_MINUS};
      7'h3d: r = {1'b0, K_EQUALS};
      7'h08: r = {1'b0, K_BKSP};
      7'h09: r = {1'b0, K_TAB};
      7'h71: r = {1'b0, K_Q};
      7'h77: r = {1'b0, K_W};
      7'h65: r = {1'b0, K_E};
      7'h72: r = {1'b0, K_R};
      7'h74: r = {1'b0, K_T};
      7'h79: r = {1'b0, K_Y};
      7'h75: r = {1'b0, K_U};
      7'h69: r = {1'b0, K_I};
      7'h6f: r = {1'b0, K_O};
      7'h70: r = {1'b0, K_P};
      7'h5b: r = {1'b0, K_LBR};
      7'h5d: r = {1'b0, K_RBR};
      7'h61: r = {1'b0, K_A};
      7'h73: r = {1'b0, K_S};
      7'h64: r = {1'b0, K_D};
      7'h66: r = {1'b0, K_F};
      7'h67: r = {1'b0, K_G};
      7'h68: r = {1'b0, K_H};
      7'h6a: r = {1'b0, K_J};
      7'h6b: r = {1'b0, K_K};
      7'h6c: r = {1'b0, K_L};
      7'h3b: r = {1'b0, K_SEMI};
      7'h27: r = {1'b0, K_QUOTE};
      7'h5c: r = {1'b0, K_BSLASH};
      7'h7a: r = {1'b0, K_Z};
      7'h78: r = {1'b0, K_X};
      7'h63: r = {1'b0, K_C};
      7'h76: r = {1'b0, K_V};
      7'h62: r = {1'b0, K_B};
      7'h6e: r = {1'b0, K_N};
      7'h6d: r = {1'b0, K_M};
      7'h2c: r = {1'b0, K_COMMA};
      7'h2e: r = {1'b0, K_PERIOD};
      7'h2f: r = {1'b0, K_SLASH};
      7'h20: r = {1'b0, K_SPACE};
      7'h0a: r = {1'b0, K_ENTER};
      7'h0d: r = {1'b0, K_ENTER};
      7'h7e: r = {1'b1, K_BACKTICK};
      7'h21: r = {1'b1, K_D1};
      7'h40: r = {1'b1, K_D2};
      7'h23: r = {1'b1, K_D3};
      7'h24: r = {1'b1, K_D4};
      7'h25: r = {1'b1, K_D5};
      7'h5e: r = {1'b1, K_D6};
      7'h26: r = {1'b1, K_D7};
      7'h2a: r = {1'b1, K_D8};
      7'h28: r = {1'b1, K_D9};
      7'h29: r = {1'b1, K_D0};
      7'h5f: r = {1'b1, K_MINUS};
      7'h2b: r = {1'b1, K_EQUALS};
      7'h51: r = {1'b1, K_Q};
      7'h57: r = {1'b1, K_W};
      7'h45: r = {1'b1, K_E};
      7'h52: r = {1'b1, K_R};
      7'h54: r = {1'b1, K_T};
      7'h59: r = {1'b1, K_Y};
      7'h55: r = {1'b1, K_U};
      7'h49: r = {1'b1, K_I};
      7'h4f: r = {1'b1, K_O};
      7'h50: r = {1'b1, K_P};
      7'h7b: r = {1'b1, K_LBR};
      7'h7d: r = {1'b1, K_RBR};
      7'h41: r = {1'b1, K_A};
      7'h53: r = {1'b1, K_S};
      7'h44: r = {1'b1, K_D};
      7'h46: r = {1'b1, K_F};
      7'h47: r = {1'b1, K_G};
      7'h48: r = {1'b1, K_H};
      7'h4a: r = {1'b1, K_J};
      7'h4b: r = {1'b1, K_K};
      7'h4c: r = {1'b1, K_L};
      7'h3a: r = {1'b1, K_SEMI};
      7'h22: r = {1'b1, K_QUOTE};
      7'h7c: r = {1'b1, K_BSLASH};
      7'h5a: r = {1'b1, K_Z};
      7'h58: r = {1'b1, K_X};
      7'h43: r = {1'b1, K_C};
      7'h56: r = {1'b1, K_V};
      7'h42: r = {1'b1, K_B};
      7'h4e: r = {1'b1, K_N};
      7'h4d: r = {1'b1, K_M};
      7'h3c: r = {1'b1, K_COMMA};
      7'h3e: r = {1'b1, K_PERIOD};
      7'h3f: r = {1'b1, K_SLASH};
      default: r = {1'b0, K_NONE};
    endcase
    return r;
  endfunction

endpackage

// ===== src/stkd_if.sv =====
`timescale 1ns / 1ps

// Byte channel from the serial receiver.
interface stkd_in_if;
  logic                        valid;
  logic                        ready;
  logic [stkd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Key event channel.
interface stkd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_release;
  logic [stkd_pkg::KeyW-1:0]   key_code;
  logic                        last_event;

  modport source (output valid, output is_release, output key_code, output last_event,
                  input ready);
  modport sink   (input valid, input is_release, input key_code, input last_event,
                  output ready);
endinterface

// ===== src/stkd_lookup.sv =====
`timescale 1ns / 1ps

// Escape sequence state machine and character table stage. A byte is taken
// when the stage register is free or drains this cycle; the table is read
// synchronously so its data lines up with the registered request.
module stkd_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [stkd_pkg::ByteW-1:0]  in_byte_i,
  output logic                        in_ready_o,
  output stkd_pkg::stkd_desc_t        desc_o,
  input  logic                        desc_take_i
);

  stkd_pkg::stkd_state_e state_q, state_d;

  logic                       valid_q;
  logic                       use_rom_q, use_rom_d;
  logic [stkd_pkg::KeyW-1:0]  key_q, key_d;
  logic                       single_q, single_d;
  logic [7:0]                 rom_q;
  logic                       accept;
  logic                       drain;

  // Stage register drains when the sequencer takes it or it holds nothing to emit.
  assign drain      = valid_q && (desc_take_i || (desc_o.key == stkd_pkg::K_NONE));
  assign in_ready_o = !valid_q || drain;
  assign accept     = in_valid_i && in_ready_o;

  // Next decoder state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stkd_pkg::ST_ESC: begin
        if (!in_byte_i[7]) begin
          if (in_byte_i == stkd_pkg::BYTE_SS3) state_d = stkd_pkg::ST_SS3;
          else if (in_byte_i == stkd_pkg::BYTE_CSI) state_d = stkd_pkg::ST_CSI;
          else state_d = stkd_pkg::ST_START;
        end
      end
      stkd_pkg::ST_CSI: begin
        if (in_byte_i == stkd_pkg::BYTE_ONE) state_d = stkd_pkg::ST_CSI1;
        else if (in_byte_i == stkd_pkg::BYTE_TWO) state_d = stkd_pkg::ST_CSI2;
        else state_d = stkd_pkg::ST_START;
      end
      stkd_pkg::ST_SS3, stkd_pkg::ST_CSI1, stkd_pkg::ST_CSI2: begin
        state_d = stkd_pkg::ST_START;
      end
      default: begin
        if (in_byte_i == stkd_pkg::BYTE_ESC) state_d = stkd_pkg::ST_ESC;
        else state_d = stkd_pkg::ST_START;
      end
    endcase
  end

  // Request decode for the byte in the current state.
  always_comb begin
    use_rom_d = 1'b0;
    key_d     = stkd_pkg::K_NONE;
    single_d  = 1'b0;
    unique case (state_q)
      stkd_pkg::ST_ESC: begin
        if (in_byte_i == stkd_pkg::BYTE_ESC) begin
          key_d    = stkd_pkg::K_ESCAPE;
          single_d = 1'b1;
        end
      end
      stkd_pkg::ST_SS3: begin
        if (in_byte_i[7:2] == 6'b010100) begin
          key_d = stkd_pkg::K_F1 + {5'd0, in_byte_i[1:0]};
        end
      end
      stkd_pkg::ST_CSI: begin
        unique case (in_byte_i)
          8'h41:   key_d = stkd_pkg::K_UP;
          8'h42:   key_d = stkd_pkg::K_DOWN;
          8'h43:   key_d = stkd_pkg::K_RIGHT;
          8'h44:   key_d = stkd_pkg::K_LEFT;
          default: key_d = stkd_pkg::K_NONE;
        endcase
      end
      stkd_pkg::ST_CSI1: begin
        unique case (in_byte_i)
          8'h35:   key_d = stkd_pkg::K_F5;
          8'h37:   key_d = stkd_pkg::K_F6;
          8'h38:   key_d = stkd_pkg::K_F7;
          8'h39:   key_d = stkd_pkg::K_F8;
          default: key_d = stkd_pkg::K_NONE;
        endcase
      end
      stkd_pkg::ST_CSI2: begin
        if (in_byte_i[7:2] == 6'b001100) begin
          key_d = stkd_pkg::K_F9 + {5'd0, in_byte_i[1:0]};
        end
      end
      default: begin
        use_rom_d = !in_byte_i[7] && (in_byte_i != stkd_pkg::BYTE_ESC);
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stkd_pkg::ST_START;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (drain) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Request payload and synchronous character table read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      use_rom_q <= use_rom_d;
      key_q     <= key_d;
      single_q  <= single_d;
      rom_q     <= stkd_pkg::ascii_lookup(in_byte_i[6:0]);
    end
  end

  // Resolved request for the sequencer.
  always_comb begin
    desc_o.valid  = valid_q;
    desc_o.key    = use_rom_q ? rom_q[6:0] : key_q;
    desc_o.shift  = use_rom_q && rom_q[7];
    desc_o.single = single_q;
  end

endmodule

// ===== src/stkd_emit.sv =====
`timescale 1ns / 1ps

// Event sequencer: walks one request through its press and release events,
// one event per cycle while the receiver is ready, from registered state.
module stkd_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stkd_pkg::stkd_desc_t        desc_i,
  output logic                        desc_take_o,
  output logic                        ev_valid_o,
  input  logic                        ev_ready_i,
  output logic                        ev_is_release_o,
  output logic [stkd_pkg::KeyW-1:0]   ev_key_code_o,
  output logic                        ev_last_event_o
);

  logic                       busy_q;
  logic [stkd_pkg::KeyW-1:0]  key_q;
  logic [1:0]                 step_q, step_d;
  logic [1:0]                 end_q, end_d;
  logic                       at_end;
  logic                       free;
  logic                       load;

  assign at_end      = (step_q == end_q);
  assign free        = !busy_q || (ev_ready_i && at_end);
  assign load        = desc_i.valid && (desc_i.key != stkd_pkg::K_NONE) && free;
  assign desc_take_o = load;

  // First and last step of the request's event sequence.
  always_comb begin
    if (desc_i.shift) begin
      step_d = stkd_pkg::STEP_SHIFT_DN;
      end_d  = stkd_pkg::STEP_SHIFT_UP;
    end else if (desc_i.single) begin
      step_d = stkd_pkg::STEP_KEY_DN;
      end_d  = stkd_pkg::STEP_KEY_DN;
    end else begin
      step_d = stkd_pkg::STEP_KEY_DN;
      end_d  = stkd_pkg::STEP_KEY_UP;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (ev_ready_i && at_end) begin
      busy_q <= 1'b0;
    end
  end

  // Sequence position and key.
  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q  <= desc_i.key;
      step_q <= step_d;
      end_q  <= end_d;
    end else if (busy_q && ev_ready_i && !at_end) begin
      step_q <= step_q + 2'd1;
    end
  end

  // Event fields.
  assign ev_valid_o      = busy_q;
  assign ev_is_release_o = step_q[1];
  assign ev_last_event_o = at_end;
  assign ev_key_code_o   = ((step_q == stkd_pkg::STEP_SHIFT_DN) ||
                            (step_q == stkd_pkg::STEP_SHIFT_UP)) ? stkd_pkg::K_LSHIFT : key_q;

endmodule

// ===== src/serial_terminal_key_decoder.sv =====
`timescale 1ns / 1ps

// The first event of a byte is offered once the byte has passed the lookup stage
// register and been loaded into the event sequencer; a busy sequencer can hold it.
// Each byte yields 1, 2 or 4 events, and the lookup stage can take the next byte
// while the sequencer still emits them; bytes with no events drain from the stage.
// The byte table is a synchronous lookup read in the acceptance cycle.
// Reset (asynchronous, active low) returns the decoder to the start state.
module serial_terminal_key_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  stkd_in_if.sink           rx_i,
  stkd_out_if.source        ev_o
);

  stkd_pkg::stkd_desc_t desc;
  logic                 desc_take;

  stkd_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_byte),
    .in_ready_o  (rx_i.ready),
    .desc_o      (desc),
    .desc_take_i (desc_take)
  );

  stkd_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .desc_i          (desc),
    .desc_take_o     (desc_take),
    .ev_valid_o      (ev_o.valid),
    .ev_ready_i      (ev_o.ready),
    .ev_is_release_o (ev_o.is_release),
    .ev_key_code_o   (ev_o.key_code),
    .ev_last_event_o (ev_o.last_event)
  );

endmodule

// ===== src/stkd_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the event stream.
module stkd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       ev_valid_i,
  input logic                       ev_ready_i,
  input logic                       ev_is_release_i,
  input logic [stkd_pkg::KeyW-1:0]  ev_key_code_i,
  input logic                       ev_last_event_i
);

  // A stalled event holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(ev_key_code_i) &&
      $stable(ev_is_release_i) && $stable(ev_last_event_i))
    else $error("stalled event changed");

  // The events of one byte follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_ready_i && !ev_last_event_i |=> ev_valid_i)
    else $error("gap inside the events of one byte");

  // Releasing shift always closes a byte's events.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_key_code_i == stkd_pkg::K_LSHIFT && ev_is_release_i |-> ev_last_event_i)
    else $error("shift release not last");

  // Escape is only ever pressed, as a single event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_key_code_i == stkd_pkg::K_ESCAPE |-> !ev_is_release_i && ev_last_event_i)
    else $error("malformed escape event");

endmodule

bind serial_terminal_key_decoder stkd_checker u_stkd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .ev_valid_i      (ev_o.valid),
  .ev_ready_i      (ev_o.ready),
  .ev_is_release_i (ev_o.is_release),
  .ev_key_code_i   (ev_o.key_code),
  .ev_last_event_i (ev_o.last_event)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import stkd_pkg::*;

  // Byte values for the character table and the escape sequences.
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_HT    = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_THREE = 8'h33;
  localparam logic [7:0] BYTE_FIVE  = 8'h35;
  localparam logic [7:0] BYTE_SEVEN = 8'h37;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] BYTE_A     = 8'h41;
  localparam logic [7:0] BYTE_C     = 8'h43;
  localparam logic [7:0] BYTE_P     = 8'h50;
  localparam logic [7:0] BYTE_S     = 8'h53;

  localparam int unsigned TotalBytes = 270;
  localparam int unsigned MaxCycles  = 200000;
  localparam int unsigned NumPhases  = 4;

  typedef struct packed {
    logic            is_release;
    logic [KeyW-1:0] key_code;
    logic            last_event;
  } key_event_t;

  logic clk_i;
  logic rst_ni;

  stkd_in_if  rx_if ();
  stkd_out_if ev_if ();

  serial_terminal_key_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .ev_o   (ev_if)
  );

  // Predictor state and the character table of the start state.
  stkd_state_e decode_state;
  logic [7:0]  char_map [128];
  key_event_t  expected_key_events [$];

  logic [7:0]  tx_bytes [$];
  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Fills consecutive key codes from a row of characters.
  function automatic void map_row(input string chars, input logic [6:0] first_key,
                                  input logic shifted);
    logic [7:0] ch;
    for (int i = 0; i < chars.len(); i++) begin
      ch = chars[i];
      char_map[ch[6:0]] = {shifted, first_key + 7'(i)};
    end
  endfunction

  // Emits press and release of a key, wrapped in left shift when shifted.
  function automatic void emit_key(input logic [6:0] key, input logic shifted);
    if (key == K_NONE) return;
    if (shifted) expected_key_events.push_back('{1'b0, K_LSHIFT, 1'b0});
    expected_key_events.push_back('{1'b0, key, 1'b0});
    expected_key_events.push_back('{1'b1, key, !shifted});
    if (shifted) expected_key_events.push_back('{1'b1, K_LSHIFT, 1'b1});
  endfunction

  // Advances the decoder state by one byte and queues the key events it causes.
  function automatic void predict_key_events(input logic [7:0] b);
    logic [6:0] key;
    logic       shifted;
    key = K_NONE;
    shifted = 1'b0;
    case (decode_state)
      ST_ESC: begin
        // High bytes after escape are dropped and the escape stays pending.
        if (b[7]) return;
        if (b == BYTE_SS3) begin
          decode_state = ST_SS3;
        end else if (b == BYTE_CSI) begin
          decode_state = ST_CSI;
        end else begin
          decode_state = ST_START;
          if (b == BYTE_ESC) expected_key_events.push_back('{1'b0, K_ESCAPE, 1'b1});
        end
      end
      ST_SS3: begin
        decode_state = ST_START;
        if (b >= BYTE_P && b <= BYTE_S) key = K_F1 + 7'(b - BYTE_P);
      end
      ST_CSI: begin
        if (b == BYTE_ONE) begin
          decode_state = ST_CSI1;
        end else if (b == BYTE_TWO) begin
          decode_state = ST_CSI2;
        end else begin
          decode_state = ST_START;
          case (b)
            BYTE_A:        key = K_UP;
            BYTE_A + 8'd1: key = K_DOWN;
            BYTE_C:        key = K_RIGHT;
            BYTE_C + 8'd1: key = K_LEFT;
            default:       key = K_NONE;
          endcase
        end
      end
      ST_CSI1: begin
        decode_state = ST_START;
        if (b == BYTE_FIVE) key = K_F5;
        else if (b >= BYTE_SEVEN && b <= BYTE_NINE) key = K_F6 + 7'(b - BYTE_SEVEN);
      end
      ST_CSI2: begin
        decode_state = ST_START;
        if (b >= BYTE_ZERO && b <= BYTE_THREE) key = K_F9 + 7'(b - BYTE_ZERO);
      end
      default: begin
        if (b == BYTE_ESC) begin
          decode_state = ST_ESC;
        end else begin
          decode_state = ST_START;
          if (!b[7]) {shifted, key} = char_map[b[6:0]];
        end
      end
    endcase
    emit_key(key, shifted);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued_total++;
  endfunction

  // One random request group: a loose byte, a well-formed escape sequence with
  // random content, or an escape sequence broken off by a random byte.
  function automatic void queue_random_sequence();
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    sel = $urandom_range(3);
    if (pick < 20) begin
      queue_byte(8'($urandom_range(8'h20, 8'h7e)));
    end else if (pick < 35) begin
      queue_byte(8'($urandom_range(255)));
    end else if (pick < 85) begin
      queue_byte(BYTE_ESC);
      case ($urandom_range(4))
        0: begin
          queue_byte(BYTE_SS3);
          queue_byte(BYTE_P + 8'(sel));
        end
        1: begin
          queue_byte(BYTE_CSI);
          queue_byte(BYTE_A + 8'(sel));
        end
        2: begin
          queue_byte(BYTE_CSI);
          queue_byte(BYTE_ONE);
          queue_byte((sel == 0) ? BYTE_FIVE : BYTE_SEVEN + 8'(sel - 1));
        end
        3: begin
          queue_byte(BYTE_CSI);
          queue_byte(BYTE_TWO);
          queue_byte(BYTE_ZERO + 8'(sel));
        end
        default: queue_byte(BYTE_ESC);
      endcase
    end else begin
      queue_byte(BYTE_ESC);
      case ($urandom_range(3))
        0: ;
        1: queue_byte(BYTE_SS3);
        2: queue_byte(BYTE_CSI);
        default: begin
          queue_byte(BYTE_CSI);
          queue_byte(sel[0] ? BYTE_ONE : BYTE_TWO);
        end
      endcase
      queue_byte(8'($urandom_range(255)));
    end
  endfunction

  // Byte driver: predicts on every accepted request and loads the next byte.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        predict_key_events(rx_if.rx_byte);
        accepted_total++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= tx_bytes.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Event receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_if.ready <= 1'b0;
    end else begin
      ev_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Event monitor: each accepted event against the oldest expectation.
  always @(posedge clk_i) begin : check_events
    key_event_t want;
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      if (expected_key_events.size() == 0) begin
        $error("unexpected key event: is_release %0d key_code %0d last_event %0d",
               ev_if.is_release, ev_if.key_code, ev_if.last_event);
        mismatch_count++;
      end else begin
        want = expected_key_events.pop_front();
        if (ev_if.is_release !== want.is_release) begin
          $error("is_release: expected %0d, actual %0d", want.is_release, ev_if.is_release);
          mismatch_count++;
        end
        if (ev_if.key_code !== want.key_code) begin
          $error("key_code: expected %0d, actual %0d", want.key_code, ev_if.key_code);
          mismatch_count++;
        end
        if (ev_if.last_event !== want.last_event) begin
          $error("last_event: expected %0d, actual %0d", want.last_event, ev_if.last_event);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("serial_terminal_key_decoder verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned idle_by_phase  [NumPhases];
    int unsigned stall_by_phase [NumPhases];
    idle_by_phase  = '{0, 49, 0, 17};
    stall_by_phase = '{0, 0, 49, 17};

    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    ev_if.ready   = 1'b0;
    decode_state  = ST_START;
    queued_total   = 0;
    accepted_total = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    for (int i = 0; i < 128; i++) char_map[i] = 8'h00;
    map_row("`1234567890-=", K_BACKTICK, 1'b0);
    map_row("qwertyuiop[]", K_Q, 1'b0);
    map_row("asdfghjkl;'\\", K_A, 1'b0);
    map_row("zxcvbnm,./", K_Z, 1'b0);
    map_row("~!@#$%^&*()_+", K_BACKTICK, 1'b1);
    map_row("QWERTYUIOP{}", K_Q, 1'b1);
    map_row("ASDFGHJKL:\"|", K_A, 1'b1);
    map_row("ZXCVBNM<>?", K_Z, 1'b1);
    char_map[BYTE_BS[6:0]]    = {1'b0, K_BKSP};
    char_map[BYTE_HT[6:0]]    = {1'b0, K_TAB};
    char_map[BYTE_LF[6:0]]    = {1'b0, K_ENTER};
    char_map[BYTE_CR[6:0]]    = {1'b0, K_ENTER};
    char_map[BYTE_SPACE[6:0]] = {1'b0, K_SPACE};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unmapped bytes at both ends, shifted key, tab, enter, double
    // escape, high byte inside an escape, each escape family, unknown after escape.
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_byte(BYTE_A);
    queue_byte(BYTE_HT);
    queue_byte(BYTE_CR);
    queue_byte(BYTE_ESC);
    queue_byte(BYTE_ESC);
    queue_byte(BYTE_ESC);
    queue_byte(8'h80);
    queue_byte(BYTE_SS3);
    queue_byte(BYTE_P);
    queue_byte(BYTE_ESC);
    queue_byte(BYTE_CSI);
    queue_byte(BYTE_C);
    queue_byte(BYTE_ESC);
    queue_byte(BYTE_CSI);
    queue_byte(BYTE_ONE);
    queue_byte(BYTE_NINE);
    queue_byte(BYTE_ESC);
    queue_byte(BYTE_CSI);
    queue_byte(BYTE_TWO);
    queue_byte(BYTE_THREE);
    queue_byte(BYTE_ESC);
    queue_byte(8'h71);
    queue_byte(8'h7f);

    // Random traffic, one share per idling profile.
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      while (queued_total < TotalBytes * (p + 1) / NumPhases) queue_random_sequence();
      while (accepted_total != queued_total) @(posedge clk_i);
    end

    while (expected_key_events.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (mismatch_count == 0 && expected_key_events.size() == 0) begin
      $display("serial_terminal_key_decoder verification clean");
    end else begin
      $display("serial_terminal_key_decoder verification failed");
    end
    $finish;
  end

endmodule
